// ----- rtl/core/two_asset_lattice_spread_pricer_defines.svh -----
// Assertion macros for the lattice pricer.
`ifndef TWO_ASSET_LATTICE_SPREAD_PRICER_DEFINES_SVH
`define TWO_ASSET_LATTICE_SPREAD_PRICER_DEFINES_SVH
`ifndef SYNTHESIS
`define TALSP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TALSP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TALSP_ASSERT_IMPL(label, clk, rst, a, c)
`define TALSP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/core/talsp_pkg.sv -----
`timescale 1ns / 1ps
package talsp_pkg;
  localparam int DEFAULT_MAX_STEPS = 64;
  localparam int PRICE_W = 32;
  localparam int WEIGHT_W = 18;
  localparam int GROWTH_W = 18;
  localparam int STEPS_W = 7;
  localparam logic [PRICE_W-1:0] FULL_SCALE = '1;

  localparam logic [2:0] REG_W_UU = 3'd0;
  localparam logic [2:0] REG_W_UD = 3'd1;
  localparam logic [2:0] REG_W_DU = 3'd2;
  localparam logic [2:0] REG_W_DD = 3'd3;
  localparam logic [2:0] REG_STRIKE = 3'd4;
  localparam logic [2:0] REG_EARLY = 3'd5;
  localparam logic [2:0] REG_G1 = 3'd6;
  localparam logic [2:0] REG_G2 = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GRID, ST_TERM_RD, ST_TERM_WR, ST_ROLL_RD, ST_ROLL_ACC,
    ST_ROLL_IMM, ST_ROLL_WR, ST_ROOT_RD, ST_ROOT_WAIT, ST_DONE
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GRID, OP_TERM_RD, OP_TERM_WR, OP_RD_SUCC,
    OP_MAC, OP_IMM_RD, OP_NODE_WR, OP_ROOT_RD, OP_ROOT_LATCH
  } op_t;

  typedef struct packed {
    op_t op;
    logic [1:0] succ;
  } dp_cmd_t;

  // Lattice indices travel as 9-bit values, enough for 2*255+1 grid levels.
  typedef struct packed {
    logic [8:0] grid_idx;
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] m;
    logic [8:0] n;
  } dp_idx_t;

  function automatic logic [PRICE_W-1:0] clamp_spread(input logic [PRICE_W-1:0] s1,
                                                     input logic [PRICE_W-1:0] s2,
                                                     input logic [PRICE_W-1:0] k);
    logic signed [PRICE_W+2:0] d;
    d = $signed({3'b0, s1}) - $signed({3'b0, s2}) - $signed({3'b0, k});
    if (d < 0) return '0;
    if (d > $signed({3'b0, FULL_SCALE})) return FULL_SCALE;
    return d[PRICE_W-1:0];
  endfunction
endpackage

// ----- rtl/core/talsp_ram.sv -----
`timescale 1ns / 1ps
module talsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/talsp_ctrl.sv -----
`timescale 1ns / 1ps
module talsp_ctrl #(
  parameter int MAX_STEPS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_go,
  input  logic [talsp_pkg::STEPS_W-1:0] steps,
  input  logic                         early,
  input  logic                         out_taken,
  output logic                         in_ready,
  output logic                         out_valid,
  output talsp_pkg::dp_cmd_t           cmd,
  output talsp_pkg::dp_idx_t           idx
);
  import talsp_pkg::*;

  state_t state, state_next;
  logic [8:0] n, grid_i, a, b, m;
  logic [8:0] n_next, grid_i_next, a_next, b_next, m_next;
  logic [1:0] succ, succ_next;
  logic [8:0] steps_clip;

  always_comb begin
    if ({2'b0, steps} > 9'(MAX_STEPS)) steps_clip = 9'(MAX_STEPS);
    else steps_clip = {2'b0, steps};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    n <= n_next;
    grid_i <= grid_i_next;
    a <= a_next;
    b <= b_next;
    m <= m_next;
    succ <= succ_next;
  end

  assign idx = '{grid_idx: grid_i, a: a, b: b, m: m, n: n};
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    n_next = n;
    grid_i_next = grid_i;
    a_next = a;
    b_next = b;
    m_next = m;
    succ_next = succ;
    cmd = '{op: OP_NONE, succ: succ};
    unique case (state)
      ST_IDLE: begin
        if (in_go) begin
          cmd.op = OP_LOAD;
          n_next = steps_clip;
          grid_i_next = 9'd1;
          a_next = '0;
          b_next = '0;
          state_next = (steps_clip == 9'd0) ? ST_TERM_RD : ST_GRID;
        end
      end
      ST_GRID: begin
        cmd.op = OP_GRID;
        if (grid_i == {n[7:0], 1'b0}) state_next = ST_TERM_RD;
        grid_i_next = grid_i + 9'd1;
      end
      ST_TERM_RD: begin
        cmd.op = OP_TERM_RD;
        state_next = ST_TERM_WR;
      end
      ST_TERM_WR: begin
        cmd.op = OP_TERM_WR;
        if (b == n) begin
          b_next = '0;
          if (a == n) begin
            a_next = '0;
            if (n == 9'd0) begin
              state_next = ST_ROOT_RD;
            end else begin
              m_next = n - 9'd1;
              succ_next = '0;
              state_next = ST_ROLL_RD;
            end
          end else begin
            a_next = a + 9'd1;
            state_next = ST_TERM_RD;
          end
        end else begin
          b_next = b + 9'd1;
          state_next = ST_TERM_RD;
        end
      end
      ST_ROLL_RD: begin
        cmd.op = OP_RD_SUCC;
        state_next = ST_ROLL_ACC;
      end
      ST_ROLL_ACC: begin
        cmd.op = OP_MAC;
        if (succ == 2'd3) begin
          succ_next = '0;
          state_next = early ? ST_ROLL_IMM : ST_ROLL_WR;
        end else begin
          succ_next = succ + 2'd1;
          state_next = ST_ROLL_RD;
        end
      end
      ST_ROLL_IMM: begin
        cmd.op = OP_IMM_RD;
        state_next = ST_ROLL_WR;
      end
      ST_ROLL_WR: begin
        cmd.op = OP_NODE_WR;
        state_next = ST_ROLL_RD;
        if (b == m) begin
          b_next = '0;
          if (a == m) begin
            a_next = '0;
            if (m == 9'd0) state_next = ST_ROOT_RD;
            else m_next = m - 9'd1;
          end else begin
            a_next = a + 9'd1;
          end
        end else begin
          b_next = b + 9'd1;
        end
      end
      ST_ROOT_RD: begin
        cmd.op = OP_ROOT_RD;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        cmd.op = OP_ROOT_LATCH;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/talsp_datapath.sv -----
`timescale 1ns / 1ps
module talsp_datapath #(
  parameter int MAX_STEPS = 64
) (
  input  logic                               clk,
  input  talsp_pkg::dp_cmd_t                 cmd,
  input  talsp_pkg::dp_idx_t                 idx,
  input  logic [talsp_pkg::PRICE_W-1:0]      first_floor_price,
  input  logic [talsp_pkg::PRICE_W-1:0]      second_floor_price,
  input  logic signed [talsp_pkg::WEIGHT_W-1:0] w_uu,
  input  logic signed [talsp_pkg::WEIGHT_W-1:0] w_ud,
  input  logic signed [talsp_pkg::WEIGHT_W-1:0] w_du,
  input  logic signed [talsp_pkg::WEIGHT_W-1:0] w_dd,
  input  logic [talsp_pkg::PRICE_W-1:0]      strike,
  input  logic                               early,
  input  logic [talsp_pkg::GROWTH_W-1:0]     g1,
  input  logic [talsp_pkg::GROWTH_W-1:0]     g2,
  output logic [talsp_pkg::PRICE_W-1:0]      price
);
  import talsp_pkg::*;

  localparam int SIDE = MAX_STEPS + 1;
  localparam int NODES = SIDE * SIDE;
  localparam int GRID_LEN = 2 * MAX_STEPS + 1;
  localparam int NA_W = $clog2(NODES);
  localparam int GA_W = $clog2(GRID_LEN);
  localparam int ACC_W = PRICE_W + WEIGHT_W + 4;

  logic [PRICE_W-1:0] prev1, prev2;
  logic [PRICE_W-1:0] g1_rd, g2_rd, n_rd;
  logic g_we, n_we;
  logic [GA_W-1:0] g_waddr, g1_raddr, g2_raddr;
  logic [PRICE_W-1:0] g1_wdata, g2_wdata, n_wdata;
  logic [NA_W-1:0] n_waddr, n_raddr;
  logic signed [ACC_W-1:0] acc;
  logic signed [WEIGHT_W-1:0] w_sel;
  logic [PRICE_W-1:0] grown1, grown2, rescaled, imm;
  logic [8:0] sa, sb, lvl1, lvl2;
  logic [15:0] node_a;
  logic signed [ACC_W-1:0] acc_r;

  function automatic logic [PRICE_W-1:0] grow(input logic [PRICE_W-1:0] p,
                                             input logic [GROWTH_W-1:0] g);
    logic [PRICE_W+GROWTH_W-1:0] prod;
    logic [PRICE_W+GROWTH_W-1:0] sh;
    prod = p * g + (PRICE_W + GROWTH_W)'(32'h8000);
    sh = prod >> 16;
    if (sh > (PRICE_W + GROWTH_W)'(FULL_SCALE)) return FULL_SCALE;
    return sh[PRICE_W-1:0];
  endfunction

  talsp_ram #(.WIDTH(PRICE_W), .DEPTH(GRID_LEN)) u_grid1 (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g1_wdata),
    .raddr(g1_raddr), .rdata(g1_rd));
  talsp_ram #(.WIDTH(PRICE_W), .DEPTH(GRID_LEN)) u_grid2 (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g2_wdata),
    .raddr(g2_raddr), .rdata(g2_rd));
  talsp_ram #(.WIDTH(PRICE_W), .DEPTH(NODES)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rd));

  assign grown1 = grow(prev1, g1);
  assign grown2 = grow(prev2, g2);

  // Successor selection: bit 1 steps the first asset, bit 0 the second.
  always_comb begin
    sa = idx.a + {8'b0, ~cmd.succ[1]};
    sb = idx.b + {8'b0, ~cmd.succ[0]};
    unique case (cmd.succ)
      2'd0: w_sel = w_uu;
      2'd1: w_sel = w_ud;
      2'd2: w_sel = w_du;
      default: w_sel = w_dd;
    endcase
  end

  always_comb begin
    lvl1 = idx.n - idx.m + {idx.a[7:0], 1'b0};
    lvl2 = idx.n - idx.m + {idx.b[7:0], 1'b0};
    g_we = (cmd.op == OP_LOAD) || (cmd.op == OP_GRID);
    g_waddr = (cmd.op == OP_LOAD) ? '0 : GA_W'(idx.grid_idx);
    g1_wdata = (cmd.op == OP_LOAD) ? first_floor_price : grown1;
    g2_wdata = (cmd.op == OP_LOAD) ? second_floor_price : grown2;
    g1_raddr = GA_W'({idx.a[7:0], 1'b0});
    g2_raddr = GA_W'({idx.b[7:0], 1'b0});
    if (cmd.op == OP_IMM_RD) begin
      g1_raddr = GA_W'(lvl1);
      g2_raddr = GA_W'(lvl2);
    end
    node_a = 16'(idx.a) * 16'(SIDE) + 16'(idx.b);
    n_raddr = NA_W'(16'(sa) * 16'(SIDE) + 16'(sb));
    if (cmd.op == OP_ROOT_RD) n_raddr = '0;
    n_waddr = NA_W'(node_a);
    n_we = (cmd.op == OP_TERM_WR) || (cmd.op == OP_NODE_WR);
    imm = clamp_spread(g1_rd, g2_rd, strike);
    if (acc_r + ACC_W'(32'sh8000) <= 0) begin
      rescaled = '0;
    end else if (((acc_r + ACC_W'(32'sh8000)) >>> 16) > $signed({10'b0, FULL_SCALE})) begin
      rescaled = FULL_SCALE;
    end else begin
      rescaled = 32'((acc_r + ACC_W'(32'sh8000)) >>> 16);
    end
    n_wdata = imm;
    if (cmd.op == OP_NODE_WR) begin
      n_wdata = (early && imm > rescaled) ? imm : rescaled;
    end
  end

  // Each product is accumulated in a register on a MAC step; the first successor's product starts a new sum.
  always_comb begin
    acc = acc_r + w_sel * $signed({1'b0, n_rd});
    if (cmd.succ == 2'd0) acc = w_sel * $signed({1'b0, n_rd});
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      prev1 <= first_floor_price;
      prev2 <= second_floor_price;
    end else if (cmd.op == OP_GRID) begin
      prev1 <= grown1;
      prev2 <= grown2;
    end
    if (cmd.op == OP_MAC) acc_r <= acc;
    if (cmd.op == OP_ROOT_LATCH) price <= n_rd;
  end
endmodule

// ----- rtl/core/two_asset_lattice_spread_pricer.sv -----
`timescale 1ns / 1ps
// Two-asset spread option pricer on a two-factor binomial lattice.
// A request beat (steps, first_floor_price, second_floor_price) is taken on
// the input channel when valid and ready are both high; ready is high only
// while the block is idle, so one request is worked on at a time.
// The block first builds both price grids, one level per cycle, then
// writes the (N+1)^2 terminal payoffs with a read and a write per node,
// then rolls back through the lattice. Each rollback node takes four
// registered reads of the node memory, each followed by one
// multiply-accumulate on a single 18x33 multiplier, a read of both grids
// with early exercise, and one write of the new node value. The node
// memory's single read port keeps the four reads one after another.
// The result beat (price) is held in a register with valid high until the
// receiver takes it; while the receiver stalls no new request is accepted.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself
// does not enforce this. A synchronous reset returns the controller to
// idle and restores the register defaults; the memories are not cleared,
// since each request writes every entry it later reads.
module two_asset_lattice_spread_pricer #(
  parameter int MAX_STEPS = talsp_pkg::DEFAULT_MAX_STEPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [talsp_pkg::STEPS_W-1:0]      steps,
  input  logic [talsp_pkg::PRICE_W-1:0]      first_floor_price,
  input  logic [talsp_pkg::PRICE_W-1:0]      second_floor_price,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [talsp_pkg::PRICE_W-1:0]      price,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [talsp_pkg::PRICE_W-1:0]      cfg_data
);
  import talsp_pkg::*;
  `include "two_asset_lattice_spread_pricer_defines.svh"

  logic signed [WEIGHT_W-1:0] w_uu, w_ud, w_du, w_dd;
  logic [PRICE_W-1:0] strike;
  logic early;
  logic [GROWTH_W-1:0] g1, g2;
  dp_cmd_t cmd;
  dp_idx_t idx;

  // Register file: every index of the three-bit space names a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_uu <= 18'sd16384;
      w_ud <= 18'sd16384;
      w_du <= 18'sd16384;
      w_dd <= 18'sd16384;
      strike <= '0;
      early <= 1'b0;
      g1 <= 18'd65536;
      g2 <= 18'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_W_UU: w_uu <= cfg_data[WEIGHT_W-1:0];
        REG_W_UD: w_ud <= cfg_data[WEIGHT_W-1:0];
        REG_W_DU: w_du <= cfg_data[WEIGHT_W-1:0];
        REG_W_DD: w_dd <= cfg_data[WEIGHT_W-1:0];
        REG_STRIKE: strike <= cfg_data;
        REG_EARLY: early <= cfg_data[0];
        REG_G1: g1 <= cfg_data[GROWTH_W-1:0];
        REG_G2: g2 <= cfg_data[GROWTH_W-1:0];
        default: ;
      endcase
    end
  end

  talsp_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_valid && in_ready), .steps(steps),
    .early(early), .out_taken(out_valid && out_ready), .in_ready(in_ready),
    .out_valid(out_valid), .cmd(cmd), .idx(idx));

  talsp_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk(clk), .cmd(cmd), .idx(idx), .first_floor_price(first_floor_price),
    .second_floor_price(second_floor_price), .w_uu(w_uu), .w_ud(w_ud),
    .w_du(w_du), .w_dd(w_dd), .strike(strike), .early(early), .g1(g1),
    .g2(g2), .price(price));

  // A request is never taken while a result is pending.
  `TALSP_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  // A stalled result beat keeps its value.
  `TALSP_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && !out_ready, $stable(price))
  // Taking the result returns the block to idle.
  `TALSP_ASSERT_NEXT(a_idle_after, clk, rst, out_valid && out_ready, in_ready)
endmodule

// ----- bench/lattice_price_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, result and register ports of the pricer. It keeps
// its own copy of the registers, prices each accepted request and compares
// every result beat with the oldest price still waiting.
module lattice_price_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [talsp_pkg::STEPS_W-1:0] steps,
  input  logic [talsp_pkg::PRICE_W-1:0] first_floor_price,
  input  logic [talsp_pkg::PRICE_W-1:0] second_floor_price,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [talsp_pkg::PRICE_W-1:0] price,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [talsp_pkg::PRICE_W-1:0] cfg_data,
  output int                            errors,
  output int                            outstanding
);
  import talsp_pkg::*;

  localparam int SIDE = DEFAULT_MAX_STEPS + 1;
  localparam int LEVELS = 2 * DEFAULT_MAX_STEPS + 1;

  logic signed [WEIGHT_W-1:0] w_uu, w_ud, w_du, w_dd;
  logic [PRICE_W-1:0] strike_k;
  logic early_ex;
  logic [GROWTH_W-1:0] g_first, g_second;
  logic [PRICE_W-1:0] price_q[$];

  function automatic logic [PRICE_W-1:0] clamp_full(input longint v);
    if (v < 0) return '0;
    if (v > longint'(FULL_SCALE)) return FULL_SCALE;
    return v[PRICE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] exercise_value(input logic [PRICE_W-1:0] s1,
                                                        input logic [PRICE_W-1:0] s2);
    return clamp_full(longint'(s1) - longint'(s2) - longint'(strike_k));
  endfunction

  function automatic logic [PRICE_W-1:0] next_level(input logic [PRICE_W-1:0] prev,
                                                    input logic [GROWTH_W-1:0] g);
    longint p;
    p = (longint'(prev) * longint'(g) + 64'sd32768) >>> 16;
    return clamp_full(p);
  endfunction

  function automatic longint weighted(input logic signed [WEIGHT_W-1:0] w,
                                      input logic [PRICE_W-1:0] v);
    return longint'(w) * longint'(v);
  endfunction

  function automatic logic [PRICE_W-1:0] lattice_root(input logic [STEPS_W-1:0] n_in,
                                                      input logic [PRICE_W-1:0] f1,
                                                      input logic [PRICE_W-1:0] f2);
    logic [PRICE_W-1:0] grid1 [0:LEVELS-1];
    logic [PRICE_W-1:0] grid2 [0:LEVELS-1];
    logic [PRICE_W-1:0] node [0:SIDE*SIDE-1];
    logic [PRICE_W-1:0] v, imm;
    longint acc;
    int n;
    n = (n_in > DEFAULT_MAX_STEPS) ? DEFAULT_MAX_STEPS : int'(n_in);
    grid1[0] = f1;
    grid2[0] = f2;
    for (int i = 1; i <= 2 * n; i++) begin
      grid1[i] = next_level(grid1[i-1], g_first);
      grid2[i] = next_level(grid2[i-1], g_second);
    end
    for (int a = 0; a <= n; a++)
      for (int b = 0; b <= n; b++)
        node[a*SIDE+b] = exercise_value(grid1[2*a], grid2[2*b]);
    // Roll back in place; a node at level m sits at grid level n-m+2a.
    for (int m = n - 1; m >= 0; m--)
      for (int a = 0; a <= m; a++)
        for (int b = 0; b <= m; b++) begin
          acc = weighted(w_uu, node[(a+1)*SIDE+b+1]) + weighted(w_ud, node[(a+1)*SIDE+b])
              + weighted(w_du, node[a*SIDE+b+1]) + weighted(w_dd, node[a*SIDE+b])
              + 64'sd32768;
          v = (acc <= 0) ? '0 : clamp_full(acc >>> 16);
          if (early_ex) begin
            imm = exercise_value(grid1[n-m+2*a], grid2[n-m+2*b]);
            if (imm > v) v = imm;
          end
          node[a*SIDE+b] = v;
        end
    return node[0];
  endfunction

  assign outstanding = price_q.size();

  always @(posedge clk) begin
    if (rst) begin
      w_uu <= 18'sd16384;
      w_ud <= 18'sd16384;
      w_du <= 18'sd16384;
      w_dd <= 18'sd16384;
      strike_k <= '0;
      early_ex <= 1'b0;
      g_first <= 18'd65536;
      g_second <= 18'd65536;
      errors <= 0;
      price_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_W_UU:   w_uu <= cfg_data[WEIGHT_W-1:0];
          REG_W_UD:   w_ud <= cfg_data[WEIGHT_W-1:0];
          REG_W_DU:   w_du <= cfg_data[WEIGHT_W-1:0];
          REG_W_DD:   w_dd <= cfg_data[WEIGHT_W-1:0];
          REG_STRIKE: strike_k <= cfg_data;
          REG_EARLY:  early_ex <= cfg_data[0];
          REG_G1:     g_first <= cfg_data[GROWTH_W-1:0];
          REG_G2:     g_second <= cfg_data[GROWTH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        price_q.push_back(lattice_root(steps, first_floor_price, second_floor_price));
      if (out_valid && out_ready) begin
        if (price_q.size() == 0) begin
          $display("%0t: unexpected price beat, expected none, actual %h", $realtime, price);
          errors <= errors + 1;
        end else begin
          if (price !== price_q[0]) begin
            $display("%0t: price mismatch, expected %h, actual %h",
                     $realtime, price_q[0], price);
            errors <= errors + 1;
          end
          void'(price_q.pop_front());
        end
      end
    end
  end
endmodule

// ----- bench/tb_two_asset_lattice_spread_pricer.sv -----
`timescale 1ns / 1ps
// Top of the bench: it makes the clock, the single reset, the request
// beats and the register writes, stalls the result side, and gives the
// verdict from the failure count and the outstanding count of the checker.
module tb_two_asset_lattice_spread_pricer;
  import talsp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STEPS_W-1:0] steps = '0;
  logic [PRICE_W-1:0] first_floor_price = '0;
  logic [PRICE_W-1:0] second_floor_price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRICE_W-1:0] price;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [PRICE_W-1:0] cfg_data = '0;

  int errors;
  int outstanding;
  // Once set, neither side idles any more.
  bit quiet = 1'b0;
  // Records that a request beat was taken at the last rising edge, so the
  // driver can look at it at the next falling edge without a race.
  logic req_taken = 1'b0;

  always #1 clk = ~clk;

  two_asset_lattice_spread_pricer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .steps(steps), .first_floor_price(first_floor_price),
    .second_floor_price(second_floor_price),
    .out_valid(out_valid), .out_ready(out_ready), .price(price),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lattice_price_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .steps(steps), .first_floor_price(first_floor_price),
    .second_floor_price(second_floor_price),
    .out_valid(out_valid), .out_ready(out_ready), .price(price),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  always @(posedge clk) req_taken <= in_valid && in_ready;

  // The result side stalls in random bursts, and is ready for stretches
  // in between, until the quiet part of the run.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && !quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [2:0] idx, input logic [PRICE_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_weights(input int uu, input int ud, input int du, input int dd);
    write_reg(REG_W_UU, uu);
    write_reg(REG_W_UD, ud);
    write_reg(REG_W_DU, du);
    write_reg(REG_W_DD, dd);
  endtask

  // Every request gives exactly one price, so an empty checker queue means
  // the block is idle and registers may be written.
  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Sends one request beat, with an optional idle burst in front of it.
  // Valid stays high until the beat is taken. The block stays busy after a
  // beat until its result is taken, so the falling edge spent with valid low
  // costs no throughput.
  task automatic send_request(input logic [STEPS_W-1:0] n, input logic [PRICE_W-1:0] f1,
                              input logic [PRICE_W-1:0] f2);
    if (!quiet && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk);
    in_valid <= 1'b1;
    steps <= n;
    first_floor_price <= f1;
    second_floor_price <= f2;
    do @(negedge clk); while (!req_taken);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A random register set: weights near a quarter most of the time, the
  // whole field now and then; full 32-bit data so the unused bits toggle.
  task automatic random_config();
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(r[2:0], $urandom());
      else
        write_reg(r[2:0], 32'(14000 + $urandom_range(0, 4000)));
    end
    write_reg(REG_STRIKE, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 22));
    write_reg(REG_EARLY, $urandom());
    write_reg(REG_G1, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(65536, 80000));
    write_reg(REG_G2, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(65536, 80000));
  endtask

  initial begin
    logic [STEPS_W-1:0] n;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero steps, a single step, and the price extremes.
    send_request(7'd0, 32'd100 << 16, 32'd40 << 16);
    send_request(7'd1, 32'd100 << 16, 32'd50 << 16);
    send_request(7'd2, 32'hFFFF_FFFF, 32'h0);
    send_request(7'd2, 32'h0, 32'hFFFF_FFFF);
    send_request(7'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Rising grids, a strike and early exercise.
    write_weights(15800, 16000, 16100, 15900);
    write_reg(REG_STRIKE, 32'd10 << 16);
    write_reg(REG_EARLY, 32'd1);
    write_reg(REG_G1, 32'd72090);
    write_reg(REG_G2, 32'd68000);
    send_request(7'd3, 32'd90 << 16, 32'd70 << 16);
    send_request(7'd5, 32'd120 << 16, 32'd60 << 16);
    // Too many steps: this one runs at the full lattice depth.
    send_request(7'd127, 32'd80 << 16, 32'd70 << 16);
    wait_drained();

    // Weight extremes with the largest growth, so grids saturate and node
    // sums go both far above full scale and below zero.
    write_weights(131071, -131072, 131071, -131072);
    write_reg(REG_G1, 32'd262143);
    write_reg(REG_G2, 32'd65536);
    write_reg(REG_EARLY, 32'd0);
    write_reg(REG_STRIKE, 32'd0);
    send_request(7'd4, 32'd1 << 16, 32'd1 << 16);
    send_request(7'd6, 32'hFFFF_0000, 32'd5);
    wait_drained();
    write_weights(-131072, 131071, -131072, 131071);
    send_request(7'd4, 32'd50 << 16, 32'd2 << 16);
    wait_drained();

    // Falling first grid, strike at full scale, early exercise on.
    write_weights(131071, 131071, 131071, 131071);
    write_reg(REG_G1, 32'd30000);
    write_reg(REG_G2, 32'd0);
    write_reg(REG_STRIKE, 32'hFFFF_FFFF);
    write_reg(REG_EARLY, 32'd1);
    send_request(7'd3, 32'hFFFF_FFFF, 32'd0);
    wait_drained();
    write_reg(REG_STRIKE, 32'd1);
    send_request(7'd5, 32'hFFFF_FFFF, 32'd3);
    send_request(7'd8, 32'd7 << 16, 32'd9 << 16);
    wait_drained();

    // Random part: a new register set every twelve requests; small
    // lattices mostly, a medium one now and then to keep the run short.
    for (int i = 0; i < 100; i++) begin
      if (i % 12 == 0) begin
        wait_drained();
        random_config();
      end
      if (i == 80) quiet = 1'b1;
      n = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(9, 20)) : 7'($urandom_range(0, 8));
      send_request(n, $urandom(), $urandom());
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("** two_asset_lattice_spread_pricer: PASSED **");
    end else begin
      $display("** two_asset_lattice_spread_pricer: FAILED **");
    end
    $finish;
  end

  // If the run has not finished within this time limit, it fails.
  initial begin
    #20_000_000;
    $display("** two_asset_lattice_spread_pricer: FAILED **");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/talsp_pkg.sv
rtl/core/talsp_ram.sv
rtl/core/talsp_ctrl.sv
rtl/core/talsp_datapath.sv
rtl/core/two_asset_lattice_spread_pricer.sv
bench/lattice_price_checker.sv
bench/tb_two_asset_lattice_spread_pricer.sv
